// ===== rtl/core/abss_pkg.sv =====
// ----------------------------------------------------------------------------
// abss_pkg
// Shared types and constants for the A/B boot slot selector.
// ----------------------------------------------------------------------------
`default_nettype none

package abss_pkg;

	localparam int PRIORITY_MAX_DEF = 15;
	localparam int TRIES_MAX_DEF    = 7;

	localparam int NSLOTS    = 3;
	localparam int FLOOR_W   = 64;
	localparam int IDX_W     = 64;
	localparam int INIT_PRI_W = 4;
	localparam int INIT_TRY_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [1:0] {
		MODE_SELECT  = 2'd0,
		MODE_ATTEMPT = 2'd1,
		MODE_SUCCESS = 2'd2,
		MODE_RELOAD  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NO_SLOT      = 2'd1,
		ST_INVALID      = 2'd2,
		ST_NOT_VERIFIED = 2'd3
	} status_t;

	localparam logic [1:0] SLOT_A    = 2'd0;
	localparam logic [1:0] SLOT_B    = 2'd1;
	localparam logic [1:0] SLOT_REC  = 2'd2;
	localparam logic [1:0] SLOT_NONE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_MASK    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_PRI_A    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_PRI_B    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_PRI_REC  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_TRIES    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_AB_FLOOR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_REC_FLOOR = 3'd6;

	localparam logic [2:0]            RST_IMAGE_MASK = 3'd0;
	localparam logic [INIT_PRI_W-1:0] RST_PRI_A      = 4'd15;
	localparam logic [INIT_PRI_W-1:0] RST_PRI_B      = 4'd14;
	localparam logic [INIT_PRI_W-1:0] RST_PRI_REC    = 4'd1;
	localparam logic [INIT_TRY_W-1:0] RST_TRIES      = 3'd7;
	localparam logic [FLOOR_W-1:0]    RST_AB_FLOOR   = '0;
	localparam logic [FLOOR_W-1:0]    RST_REC_FLOOR  = '0;

	typedef struct packed {
		logic [2:0]            image_present_mask;
		logic [INIT_PRI_W-1:0] init_priority_a;
		logic [INIT_PRI_W-1:0] init_priority_b;
		logic [INIT_PRI_W-1:0] init_priority_rec;
		logic [INIT_TRY_W-1:0] init_tries;
		logic [FLOOR_W-1:0]    init_boot_floor;
		logic [FLOOR_W-1:0]    init_recovery_floor;
	} abss_cfg_t;

	typedef struct packed {
		mode_t            mode;
		logic [1:0]       slot;
		logic             verify_ok_a;
		logic             verify_ok_b;
		logic             verify_ok_rec;
		logic [IDX_W-1:0] index_a;
		logic [IDX_W-1:0] index_b;
		logic [IDX_W-1:0] index_rec;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic [1:0]         chosen_slot;
		logic [FLOOR_W-1:0] boot_floor;
		logic [FLOOR_W-1:0] recovery_floor;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/abss_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// abss_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module abss_cfg_regs
	import abss_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output abss_cfg_t                  cfg
);

	abss_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_present_mask  <= RST_IMAGE_MASK;
			cfg_q.init_priority_a     <= RST_PRI_A;
			cfg_q.init_priority_b     <= RST_PRI_B;
			cfg_q.init_priority_rec   <= RST_PRI_REC;
			cfg_q.init_tries          <= RST_TRIES;
			cfg_q.init_boot_floor     <= RST_AB_FLOOR;
			cfg_q.init_recovery_floor <= RST_REC_FLOOR;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_IMAGE_MASK:     cfg_q.image_present_mask  <= cfg_wdata[2:0];
				CFG_INIT_PRI_A:     cfg_q.init_priority_a     <= cfg_wdata[INIT_PRI_W-1:0];
				CFG_INIT_PRI_B:     cfg_q.init_priority_b     <= cfg_wdata[INIT_PRI_W-1:0];
				CFG_INIT_PRI_REC:   cfg_q.init_priority_rec   <= cfg_wdata[INIT_PRI_W-1:0];
				CFG_INIT_TRIES:     cfg_q.init_tries          <= cfg_wdata[INIT_TRY_W-1:0];
				CFG_INIT_AB_FLOOR:  cfg_q.init_boot_floor     <= cfg_wdata[FLOOR_W-1:0];
				CFG_INIT_REC_FLOOR: cfg_q.init_recovery_floor <= cfg_wdata[FLOOR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/abss_slot_table.sv =====
// ----------------------------------------------------------------------------
// abss_slot_table
// Slot table and rollback floors with the one-pass command logic.
// ----------------------------------------------------------------------------
`default_nettype none

module abss_slot_table
	import abss_pkg::*;
#(
	parameter int PRIORITY_MAX = PRIORITY_MAX_DEF,
	parameter int TRIES_MAX    = TRIES_MAX_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire abss_cfg_t cfg,
	input  wire logic      vld_s1,
	input  wire cmd_t      cmd_s1,
	output result_t        res
);

	localparam int PRIO_W  = $clog2(PRIORITY_MAX + 1);
	localparam int TRIES_W = $clog2(TRIES_MAX + 1);
	localparam logic [PRIO_W-1:0]  PRIO_TOP  = PRIO_W'(PRIORITY_MAX);
	localparam logic [PRIO_W-1:0]  PRIO_DEMOTE = PRIO_W'(PRIORITY_MAX - 1);
	localparam logic [TRIES_W-1:0] TRIES_TOP = TRIES_W'(TRIES_MAX);

	function automatic logic [PRIO_W-1:0] sat_prio(input logic [INIT_PRI_W-1:0] v);
		if (32'(v) > 32'(PRIORITY_MAX))
			return PRIO_TOP;
		return PRIO_W'(v);
	endfunction

	function automatic logic [TRIES_W-1:0] sat_tries(input logic [INIT_TRY_W-1:0] v);
		if (32'(v) > 32'(TRIES_MAX))
			return TRIES_TOP;
		return TRIES_W'(v);
	endfunction

	logic [PRIO_W-1:0]  pri_q   [NSLOTS];
	logic [TRIES_W-1:0] tries_q [NSLOTS];
	logic [NSLOTS-1:0]  pinned_q;
	logic [NSLOTS-1:0]  dead_q;
	logic [IDX_W-1:0]   rb_q    [NSLOTS];
	logic [FLOOR_W-1:0] ab_floor_q;
	logic [FLOOR_W-1:0] rec_floor_q;

	logic [PRIO_W-1:0]  pri_n   [NSLOTS];
	logic [TRIES_W-1:0] tries_n [NSLOTS];
	logic [NSLOTS-1:0]  pinned_n;
	logic [NSLOTS-1:0]  dead_n;
	logic [IDX_W-1:0]   rb_n    [NSLOTS];
	logic [FLOOR_W-1:0] ab_floor_n;
	logic [FLOOR_W-1:0] rec_floor_n;

	logic [1:0] elig;
	logic       b_first;
	logic       choose_a, choose_b, choose_r;
	logic       kill_a, kill_b, kill_r;
	logic       rec_live;
	logic [IDX_W-1:0] rb_sel;
	logic       sel_present;
	status_t    status;
	logic [1:0] chosen;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			elig[i] = !dead_q[i] && (pri_q[i] != '0) &&
				((tries_q[i] != '0) || pinned_q[i]) && cfg.image_present_mask[i];
		end
	end

	assign b_first  = pri_q[1] > pri_q[0];
	assign choose_a = elig[0] && cmd_s1.verify_ok_a &&
		(!b_first || !(elig[1] && cmd_s1.verify_ok_b));
	assign choose_b = elig[1] && cmd_s1.verify_ok_b &&
		(b_first || !(elig[0] && cmd_s1.verify_ok_a));
	assign kill_a   = elig[0] && !cmd_s1.verify_ok_a && !(b_first && choose_b);
	assign kill_b   = elig[1] && !cmd_s1.verify_ok_b && !(!b_first && choose_a);
	assign rec_live = !choose_a && !choose_b && !dead_q[SLOT_REC] &&
		cfg.image_present_mask[SLOT_REC];
	assign choose_r = rec_live && cmd_s1.verify_ok_rec;
	assign kill_r   = rec_live && !cmd_s1.verify_ok_rec;

	always_comb begin
		case (cmd_s1.slot)
			SLOT_A:   rb_sel = rb_q[0];
			SLOT_B:   rb_sel = rb_q[1];
			SLOT_REC: rb_sel = rb_q[2];
			default:  rb_sel = '0;
		endcase
	end

	assign sel_present = (cmd_s1.slot != SLOT_NONE) &&
		cfg.image_present_mask[cmd_s1.slot];

	always_comb begin
		pri_n       = pri_q;
		tries_n     = tries_q;
		pinned_n    = pinned_q;
		dead_n      = dead_q;
		rb_n        = rb_q;
		ab_floor_n  = ab_floor_q;
		rec_floor_n = rec_floor_q;
		status      = ST_OK;
		chosen      = SLOT_NONE;
		case (cmd_s1.mode)
			MODE_SELECT: begin
				if (choose_a) begin
					rb_n[0] = cmd_s1.index_a;
					chosen  = SLOT_A;
				end
				if (choose_b) begin
					rb_n[1] = cmd_s1.index_b;
					chosen  = SLOT_B;
				end
				if (choose_r) begin
					rb_n[2] = cmd_s1.index_rec;
					chosen  = SLOT_REC;
				end
				dead_n[0] = dead_q[0] | kill_a;
				dead_n[1] = dead_q[1] | kill_b;
				dead_n[2] = dead_q[2] | kill_r;
				if (!choose_a && !choose_b && !choose_r)
					status = ST_NO_SLOT;
			end
			MODE_RELOAD: begin
				pri_n[0] = sat_prio(cfg.init_priority_a);
				pri_n[1] = sat_prio(cfg.init_priority_b);
				pri_n[2] = sat_prio(cfg.init_priority_rec);
				for (int i = 0; i < NSLOTS; i++) begin
					tries_n[i] = sat_tries(cfg.init_tries);
					rb_n[i]    = '0;
				end
				pinned_n    = '0;
				dead_n      = '0;
				ab_floor_n  = cfg.init_boot_floor;
				rec_floor_n = cfg.init_recovery_floor;
			end
			MODE_ATTEMPT: begin
				if (cmd_s1.slot == SLOT_NONE) begin
					status = ST_INVALID;
				end else begin
					for (int i = 0; i < NSLOTS; i++) begin
						if (cmd_s1.slot == 2'(i) && !pinned_q[i]) begin
							if (tries_q[i] != '0)
								tries_n[i] = tries_q[i] - TRIES_W'(1);
							if (tries_n[i] == '0)
								dead_n[i] = 1'b1;
						end
					end
				end
			end
			MODE_SUCCESS: begin
				if (cmd_s1.slot == SLOT_NONE) begin
					status = ST_INVALID;
				end else if (!sel_present) begin
					status = ST_NOT_VERIFIED;
				end else begin
					for (int i = 0; i < NSLOTS; i++) begin
						if (cmd_s1.slot == 2'(i)) begin
							pinned_n[i] = 1'b1;
							tries_n[i]  = '0;
							dead_n[i]   = 1'b0;
							pri_n[i]    = PRIO_TOP;
						end else if (i < 2 && cmd_s1.slot != SLOT_REC) begin
							if (pri_q[i] >= PRIO_TOP)
								pri_n[i] = PRIO_DEMOTE;
						end
					end
					if (cmd_s1.slot == SLOT_REC) begin
						if (rb_sel > rec_floor_q)
							rec_floor_n = rb_sel;
					end else begin
						if (rb_sel > ab_floor_q)
							ab_floor_n = rb_sel;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pri_q[0] <= sat_prio(RST_PRI_A);
			pri_q[1] <= sat_prio(RST_PRI_B);
			pri_q[2] <= sat_prio(RST_PRI_REC);
			for (int i = 0; i < NSLOTS; i++) begin
				tries_q[i] <= sat_tries(RST_TRIES);
				rb_q[i]    <= '0;
			end
			pinned_q    <= '0;
			dead_q      <= '0;
			ab_floor_q  <= RST_AB_FLOOR;
			rec_floor_q <= RST_REC_FLOOR;
		end else if (vld_s1) begin
			pri_q       <= pri_n;
			tries_q     <= tries_n;
			pinned_q    <= pinned_n;
			dead_q      <= dead_n;
			rb_q        <= rb_n;
			ab_floor_q  <= ab_floor_n;
			rec_floor_q <= rec_floor_n;
		end
	end

	assign res.status         = status;
	assign res.chosen_slot    = chosen;
	assign res.boot_floor     = ab_floor_n;
	assign res.recovery_floor = rec_floor_n;

endmodule

`default_nettype wire

// ===== rtl/core/ab_boot_slot_selector.sv =====
// Timing: a taken command passes through the input register, then the result
//   register, which raises done and holds the result beat.
// Throughput: one command every cycle; busy stays low and results cannot be held off.
// Reset: configuration returns to its defaults and the slot table and both
//   rollback floors load as on a reload with those defaults.
// ----------------------------------------------------------------------------
// ab_boot_slot_selector
// A/B boot slot selection with retry counting, pinning and rollback floors.
// ----------------------------------------------------------------------------
`default_nettype none

module ab_boot_slot_selector
	import abss_pkg::*;
#(
	parameter int PRIORITY_MAX = PRIORITY_MAX_DEF,
	parameter int TRIES_MAX    = TRIES_MAX_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  start,
	output logic                       busy,
	input  wire cmd_t                  cmd,
	output logic                       done,
	output result_t                    result
);

	abss_cfg_t cfg;
	logic      vld_s1;
	cmd_t      cmd_s1;
	result_t   res;
	logic      done_q;
	result_t   res_q;

	assign busy = 1'b0;

	abss_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy)
			cmd_s1 <= cmd;
		if (vld_s1)
			res_q <= res;
	end

	abss_slot_table #(
		.PRIORITY_MAX (PRIORITY_MAX),
		.TRIES_MAX    (TRIES_MAX)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.vld_s1 (vld_s1),
		.cmd_s1 (cmd_s1),
		.res    (res)
	);

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/abss_checker.sv =====
// ----------------------------------------------------------------------------
// abss_checker
// Port-level checks on the A/B boot slot selector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module abss_checker
	import abss_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire cmd_t    cmd,
	input wire logic    done,
	input wire result_t result
);

	a_done_follows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("done without an accepted beat two cycles earlier");

	a_chosen_means_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.chosen_slot != SLOT_NONE) |-> result.status == ST_OK)
		else $error("slot chosen with a failing status");

	a_invalid_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_INVALID) |-> $past(cmd.slot, 2) == SLOT_NONE)
		else $error("invalid status for a valid slot");

	a_floor_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && $past(cmd.mode, 2) != MODE_RELOAD) |->
		(result.boot_floor >= $past(result.boot_floor) &&
		 result.recovery_floor >= $past(result.recovery_floor)))
		else $error("rollback floor lowered outside a reload");

endmodule

bind ab_boot_slot_selector abss_checker u_abss_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);

`default_nettype wire
